[sv/q2e_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package q2e_pkg;

  // Default build values for the top-level parameters
  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // Datapath widths
  localparam int unsigned QW     = 16;  // quaternion component
  localparam int unsigned PROD_W = 32;  // product of two components
  localparam int unsigned SUM_W  = 35;  // sine and cosine terms at 2^30 scale
  localparam int unsigned SQ_W   = 62;  // square of the pitch sine
  localparam int unsigned REM_W  = 61;  // radicand, up to 2^60
  localparam int unsigned ROOT_W = 31;  // square root, up to 2^30
  localparam int unsigned SQRT_N = 31;  // one cell per root bit
  localparam int unsigned CORD_W = 37;  // CORDIC vector width
  localparam int unsigned EXT_W  = 18;  // angle after output scaling, before wrap
  localparam int unsigned OUT_W  = 16;  // angle field

  // Pitch limits, half pi in output angle units
  localparam logic signed [EXT_W-1:0] HALF_PI_OUT = EXT_W'(16384);

  // atan(2^-i) with pi = 2^31
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] roll;
    logic signed [OUT_W-1:0] pitch;
    logic signed [OUT_W-1:0] yaw;
    logic                    pitch_clamped;
  } euler_t;

  // Micro-rotation angle of one stage, rounded half up to the accumulator width
  function automatic logic [31:0] step_angle(input int unsigned idx, input int unsigned ab);
    logic [32:0]  s;
    int unsigned  sh;
    sh = 32 - ab;
    if (sh == 0) begin
      s = {1'b0, ATAN_TAB[idx & 31]};
    end else begin
      s = ({1'b0, ATAN_TAB[idx & 31]} + (33'd1 << (sh - 1))) >> sh;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

[sv/q2e_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One bit of a restoring square root; side data rides along unchanged
module q2e_sqrt_cell import q2e_pkg::*; #(
  parameter int unsigned BIT    = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [REM_W-1:0]  rem_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [REM_W-1:0]       rem_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int unsigned TW = 64;

  logic [TW-1:0]     trial, rem_ext, diff;
  logic              take;
  logic              vld_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [SIDE_W-1:0] side_q;

  // Try this root bit: subtract (2*root + 2^bit) * 2^bit from the remainder
  assign trial   = ({{(TW-ROOT_W){1'b0}}, root_i} << (BIT + 1))
                 + ({{(TW-1){1'b0}}, 1'b1} << (2 * BIT));
  assign rem_ext = {{(TW-REM_W){1'b0}}, rem_i};
  assign take    = rem_ext >= trial;
  assign diff    = rem_ext - trial;
  assign rem_d   = take ? diff[REM_W-1:0] : rem_i;
  assign root_d  = take ? (root_i | (ROOT_W'(1) << BIT)) : root_i;

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

[sv/q2e_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One vectoring CORDIC micro-rotation; drives y toward zero
module q2e_cordic_cell import q2e_pkg::*; #(
  parameter int unsigned STAGE  = 0,
  parameter int unsigned AB     = 16,
  parameter int unsigned ZW     = 18,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire logic signed [CORD_W-1:0] x_i,
  input  wire logic signed [CORD_W-1:0] y_i,
  input  wire logic signed [ZW-1:0]     z_i,
  input  wire logic [SIDE_W-1:0]        side_i,
  output logic                          vld_o,
  output logic signed [CORD_W-1:0]      x_o,
  output logic signed [CORD_W-1:0]      y_o,
  output logic signed [ZW-1:0]          z_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam logic signed [ZW-1:0] T = ZW'(step_angle(STAGE, AB));

  logic signed [CORD_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0]     z_d, z_q;
  logic                     vld_q;
  logic [SIDE_W-1:0]        side_q;

  // Shifts round toward minus infinity
  assign dx = y_i >>> STAGE;
  assign dy = x_i >>> STAGE;

  always_comb begin
    if (!y_i[CORD_W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + T;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - T;
    end
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

[sv/quaternion_to_euler.sv]
// Throughput: one word per cycle; every stage is a register and the whole chain
// moves together, held only while the output register waits on out_ready_i.
// The chain is 4 product/sum stages, 31 square-root cells, one quadrant stage,
// CORDIC_STAGES CORDIC cells per angle and the output register.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_euler import q2e_pkg::*; #(
  parameter int unsigned ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire quat_t  in_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output euler_t      out_o
);

  localparam int unsigned ZW     = ANGLE_BITS + 2;
  localparam int unsigned N      = CORDIC_STAGES;
  localparam int unsigned SH     = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int unsigned LS     = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam longint      HALF   = (SH == 0) ? 0 : (64'd1 << (SH - 1));
  localparam int unsigned SSIDE  = 4 * SUM_W + ROOT_W + 2;
  localparam int unsigned CSIDE  = 3;
  localparam int unsigned LANES  = 3;
  localparam int unsigned L_ROLL  = 0;
  localparam int unsigned L_PITCH = 1;
  localparam int unsigned L_YAW   = 2;

  localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1 <<< 30);
  localparam logic [REM_W-1:0]        ONE_Q60 = REM_W'(1) << 60;
  localparam logic signed [ZW-1:0]    PI_Z    = ZW'(64'sd1 <<< (ANGLE_BITS - 1));

  logic en;

  // ---------------- Stage 0: products ----------------
  logic                     s0_vld_q;
  logic signed [PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= in_i.quat_w * in_i.quat_x;
      yz_q <= in_i.quat_y * in_i.quat_z;
      xx_q <= in_i.quat_x * in_i.quat_x;
      yy_q <= in_i.quat_y * in_i.quat_y;
      wy_q <= in_i.quat_w * in_i.quat_y;
      zx_q <= in_i.quat_z * in_i.quat_x;
      wz_q <= in_i.quat_w * in_i.quat_z;
      xy_q <= in_i.quat_x * in_i.quat_y;
      zz_q <= in_i.quat_z * in_i.quat_z;
    end
  end

  // ---------------- Stage 1: sine and cosine terms ----------------
  logic                    s1_vld_q;
  logic signed [SUM_W-1:0] sr_d, cr_d, sp_d, sy_d, cy_d;
  logic signed [SUM_W-1:0] sr_q, cr_q, sp_q, sy_q, cy_q;

  assign sr_d = (SUM_W'(wx_q) + SUM_W'(yz_q)) <<< 1;
  assign cr_d = ONE_Q30 - ((SUM_W'(xx_q) + SUM_W'(yy_q)) <<< 1);
  assign sp_d = (SUM_W'(wy_q) - SUM_W'(zx_q)) <<< 1;
  assign sy_d = (SUM_W'(wz_q) + SUM_W'(xy_q)) <<< 1;
  assign cy_d = ONE_Q30 - ((SUM_W'(yy_q) + SUM_W'(zz_q)) <<< 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q <= sr_d;
      cr_q <= cr_d;
      sp_q <= sp_d;
      sy_q <= sy_d;
      cy_q <= cy_d;
    end
  end

  // ---------------- Stage 2: pitch sine squared, clamp test ----------------
  logic                     s2_vld_q, s2_clamp_q;
  logic signed [ROOT_W-1:0] sp31;
  logic signed [SQ_W-1:0]   sq_q;
  logic signed [SUM_W-1:0]  s2_sr_q, s2_cr_q, s2_sy_q, s2_cy_q, s2_sp_q;

  assign sp31 = sp_q[ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q       <= SQ_W'(sp31) * SQ_W'(sp31);
      s2_clamp_q <= (sp_q >= ONE_Q30) || (sp_q <= -ONE_Q30);
      s2_sr_q    <= sr_q;
      s2_cr_q    <= cr_q;
      s2_sy_q    <= sy_q;
      s2_cy_q    <= cy_q;
      s2_sp_q    <= sp_q;
    end
  end

  // ---------------- Stage 3: radicand ----------------
  logic              s3_vld_q;
  logic [REM_W-1:0]  s3_rem_q;
  logic [SSIDE-1:0]  s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rem_q  <= s2_clamp_q ? '0 : (ONE_Q60 - sq_q[REM_W-1:0]);
      s3_side_q <= {s2_sr_q, s2_cr_q, s2_sy_q, s2_cy_q, s2_sp_q[ROOT_W-1:0],
                    s2_clamp_q, s2_sp_q[SUM_W-1]};
    end
  end

  // ---------------- Square root cells, one root bit each ----------------
  logic              sq_vld  [SQRT_N+1];
  logic [REM_W-1:0]  sq_rem  [SQRT_N+1];
  logic [ROOT_W-1:0] sq_root [SQRT_N+1];
  logic [SSIDE-1:0]  sq_side [SQRT_N+1];

  assign sq_vld[0]  = s3_vld_q;
  assign sq_rem[0]  = s3_rem_q;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3_side_q;

  for (genvar j = 0; j < SQRT_N; j++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT    (SQRT_N - 1 - j),
      .SIDE_W (SSIDE)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .side_i (sq_side[j]),
      .vld_o  (sq_vld[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .side_o (sq_side[j+1])
    );
  end

  // ---------------- Quadrant stage: turn left-half vectors by pi ----------------
  logic signed [SUM_W-1:0]  q_sr, q_cr, q_sy, q_cy;
  logic signed [ROOT_W-1:0] q_sp;
  logic                     q_clamp, q_sign;
  logic signed [CORD_W-1:0] px [LANES];
  logic signed [CORD_W-1:0] py [LANES];

  assign {q_sr, q_cr, q_sy, q_cy, q_sp, q_clamp, q_sign} = sq_side[SQRT_N];

  assign px[L_ROLL]  = CORD_W'(q_cr);
  assign py[L_ROLL]  = CORD_W'(q_sr);
  assign px[L_PITCH] = CORD_W'({1'b0, sq_root[SQRT_N]});
  assign py[L_PITCH] = CORD_W'(q_sp);
  assign px[L_YAW]   = CORD_W'(q_cy);
  assign py[L_YAW]   = CORD_W'(q_sy);

  logic                     cv [LANES][N+1];
  logic signed [CORD_W-1:0] cx [LANES][N+1];
  logic signed [CORD_W-1:0] cy [LANES][N+1];
  logic signed [ZW-1:0]     cz [LANES][N+1];
  logic [CSIDE-1:0]         cs [LANES][N+1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic                     pv_q;
    logic signed [CORD_W-1:0] px_q, py_q;
    logic signed [ZW-1:0]     pz_q;
    logic [CSIDE-1:0]         ps_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q <= 1'b0;
      end else if (en) begin
        pv_q <= sq_vld[SQRT_N];
      end
    end

    // Zero vector flagged here; side also carries the pitch clamp and sign
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (px[l][CORD_W-1]) begin
          px_q <= -px[l];
          py_q <= -py[l];
          pz_q <= py[l][CORD_W-1] ? -PI_Z : PI_Z;
        end else begin
          px_q <= px[l];
          py_q <= py[l];
          pz_q <= '0;
        end
        ps_q <= {(px[l] == '0) && (py[l] == '0),
                 (l == L_PITCH) ? q_clamp : 1'b0,
                 (l == L_PITCH) ? q_sign : 1'b0};
      end
    end

    assign cv[l][0] = pv_q;
    assign cx[l][0] = px_q;
    assign cy[l][0] = py_q;
    assign cz[l][0] = pz_q;
    assign cs[l][0] = ps_q;

    for (genvar i = 0; i < N; i++) begin : g_stage
      q2e_cordic_cell #(
        .STAGE  (i),
        .AB     (ANGLE_BITS),
        .ZW     (ZW),
        .SIDE_W (CSIDE)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .vld_i  (cv[l][i]),
        .x_i    (cx[l][i]),
        .y_i    (cy[l][i]),
        .z_i    (cz[l][i]),
        .side_i (cs[l][i]),
        .vld_o  (cv[l][i+1]),
        .x_o    (cx[l][i+1]),
        .y_o    (cy[l][i+1]),
        .z_o    (cz[l][i+1]),
        .side_o (cs[l][i+1])
      );
    end
  end

  // ---------------- Output scaling and pitch limit ----------------
  logic signed [ZW:0]      zr   [LANES];
  logic signed [EXT_W-1:0] ang  [LANES];
  logic signed [EXT_W-1:0] pitch_ext;
  logic                    fin_clamp, fin_sign, fin_vld;
  euler_t                  res_d, out_q;
  logic                    out_vld_q;

  for (genvar l = 0; l < LANES; l++) begin : g_scale
    assign zr[l]  = (ZW+1)'(cz[l][N]) + (ZW+1)'(HALF);
    assign ang[l] = cs[l][N][2] ? '0 : (EXT_W'(zr[l] >>> SH) <<< LS);
  end

  assign fin_clamp = cs[L_PITCH][N][1];
  assign fin_sign  = cs[L_PITCH][N][0];
  assign fin_vld   = cv[L_ROLL][N] & cv[L_PITCH][N] & cv[L_YAW][N];

  always_comb begin
    if (fin_clamp) begin
      pitch_ext = fin_sign ? -HALF_PI_OUT : HALF_PI_OUT;
    end else if (ang[L_PITCH] > HALF_PI_OUT) begin
      pitch_ext = HALF_PI_OUT;
    end else if (ang[L_PITCH] < -HALF_PI_OUT) begin
      pitch_ext = -HALF_PI_OUT;
    end else begin
      pitch_ext = ang[L_PITCH];
    end
    res_d.roll          = ang[L_ROLL][OUT_W-1:0];
    res_d.pitch         = pitch_ext[OUT_W-1:0];
    res_d.yaw           = ang[L_YAW][OUT_W-1:0];
    res_d.pitch_clamped = fin_clamp;
  end

  // Hold the result until taken; the chain stalls behind it
  assign en = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= fin_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // ---------------- Assertions ----------------
  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.pitch_clamped |->
      (out_o.pitch == 16'sd16384) || (out_o.pitch == -16'sd16384))
    else $error("clamped pitch not at half pi");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.pitch <= 16'sd16384) && (out_o.pitch >= -16'sd16384))
    else $error("pitch out of range");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv[L_ROLL][N] == cv[L_PITCH][N]) && (cv[L_YAW][N] == cv[L_PITCH][N]))
    else $error("CORDIC lanes out of step");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(fin_vld) && out_valid_o)
    else $error("chain moved during stall");

endmodule

`default_nettype wire

[tb/quaternion_to_euler_tb.sv]
`timescale 1ns / 1ps

module quaternion_to_euler_tb;
  import q2e_pkg::*;

  localparam int unsigned N_RANDOM = 1500;
  localparam int unsigned TAIL_CYCLES = 80;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  quat_t  in_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  euler_t out_o;

  quat_t  pending_quats[$];
  bit     drain_marks[$];
  euler_t expected_angles[$];

  int     mismatch_cnt = 0;
  int     sent_cnt = 0;
  int     checked_cnt = 0;
  int     clamped_cnt = 0;
  int     drain_cnt = 0;
  bit     took = 1'b0;
  bit     burst_mode = 1'b0;
  int     send_gap = 0;
  int     stall_left = 0;

  quaternion_to_euler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Vectoring CORDIC, angle in output units (pi = 32768 at 16 accumulator bits)
  function automatic longint vector_angle(input longint sin_t, input longint cos_t);
    longint acc;
    longint dx;
    longint dy;
    longint step;
    longint pi_val;
    acc = 0;
    pi_val = longint'(1) << (ANGLE_BITS_DEF - 1);
    if (sin_t == 0 && cos_t == 0) return 0;
    // Turn the vector by pi into the right half plane
    if (cos_t < 0) begin
      acc = (sin_t >= 0) ? pi_val : -pi_val;
      cos_t = -cos_t;
      sin_t = -sin_t;
    end
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = sin_t >>> i;
      dy = cos_t >>> i;
      step = (longint'(ATAN_TAB[i]) + (longint'(1) << (31 - ANGLE_BITS_DEF)))
             >>> (32 - ANGLE_BITS_DEF);
      if (sin_t >= 0) begin
        cos_t += dx;
        sin_t -= dy;
        acc += step;
      end else begin
        cos_t -= dx;
        sin_t += dy;
        acc -= step;
      end
    end
    return acc;
  endfunction

  function automatic longint root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t euler_of(input quat_t q);
    euler_t r;
    longint one;
    longint w;
    longint x;
    longint y;
    longint z;
    longint sr;
    longint cr;
    longint sp;
    longint sy;
    longint cy;
    longint cp;
    longint p;
    one = longint'(1) << 30;
    w = q.quat_w;
    x = q.quat_x;
    y = q.quat_y;
    z = q.quat_z;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    r.roll = 16'(vector_angle(sr, cr));
    r.yaw = 16'(vector_angle(sy, cy));
    r.pitch_clamped = 1'b0;
    // Clamp pitch at gimbal lock, else take asin through atan2
    if (sp >= one) begin
      p = 16384;
      r.pitch_clamped = 1'b1;
    end else if (sp <= -one) begin
      p = -16384;
      r.pitch_clamped = 1'b1;
    end else begin
      cp = root_floor(longint'((longint'(1) << 60) - sp * sp));
      p = vector_angle(sp, cp);
      if (p > 16384) p = 16384;
      if (p < -16384) p = -16384;
    end
    r.pitch = 16'(p);
    return r;
  endfunction

  function automatic int pick_gap();
    if (burst_mode) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  function automatic quat_t quat_of(input int w, input int x, input int y, input int z);
    quat_t q;
    q.quat_w = 16'(w);
    q.quat_x = 16'(x);
    q.quat_y = 16'(y);
    q.quat_z = 16'(z);
    return q;
  endfunction

  task automatic queue_quat(input quat_t q, input bit drain);
    pending_quats.push_back(q);
    drain_marks.push_back(drain);
  endtask

  // Random unit quaternion scaled to Q1.15
  function automatic quat_t unit_quat();
    real c[4];
    real n;
    int v[4];
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'($signed($urandom_range(0, 65535)) - 32768);
      n += c[i] * c[i];
    end
    if (n == 0.0) return quat_of(32767, 0, 0, 0);
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) begin
      v[i] = $rtoi(c[i] / n * 32767.0);
    end
    return quat_of(v[0], v[1], v[2], v[3]);
  endfunction

  task automatic fill_stimulus();
    int s;
    int d;
    // Directed corners: zero, identity, full scale, half-pi rolls, gimbal lock
    queue_quat(quat_of(0, 0, 0, 0), 1'b0);
    queue_quat(quat_of(32767, 0, 0, 0), 1'b0);
    queue_quat(quat_of(-32768, 0, 0, 0), 1'b0);
    queue_quat(quat_of(0, 32767, 0, 0), 1'b0);
    queue_quat(quat_of(0, -32768, 0, 0), 1'b0);
    queue_quat(quat_of(0, 0, 32767, 0), 1'b0);
    queue_quat(quat_of(0, 0, 0, 32767), 1'b0);
    queue_quat(quat_of(0, 0, 0, -32768), 1'b0);
    queue_quat(quat_of(-32768, -32768, -32768, -32768), 1'b0);
    queue_quat(quat_of(32767, 32767, 32767, 32767), 1'b0);
    queue_quat(quat_of(-32768, 32767, -32768, 32767), 1'b0);
    queue_quat(quat_of(23170, 0, 23170, 0), 1'b0);
    queue_quat(quat_of(23171, 0, 23171, 0), 1'b0);
    queue_quat(quat_of(23170, 0, -23170, 0), 1'b0);
    queue_quat(quat_of(23171, 0, -23171, 0), 1'b0);
    queue_quat(quat_of(0, 23171, 0, -23171), 1'b0);
    queue_quat(quat_of(23170, 23170, 0, 0), 1'b0);
    queue_quat(quat_of(23170, -23170, 0, 0), 1'b0);
    queue_quat(quat_of(-16384, 16384, 16384, -16384), 1'b0);
    queue_quat(quat_of(1, -1, 1, -1), 1'b1);
    // Random part: mostly unit quaternions, some near gimbal lock, some raw
    for (int k = 0; k < N_RANDOM; k++) begin
      s = $urandom_range(0, 9);
      if (s < 6) begin
        queue_quat(unit_quat(), (k % 500) == 250);
      end else if (s < 8) begin
        d = $urandom_range(0, 1) ? 1 : -1;
        queue_quat(quat_of(23170 + $urandom_range(0, 60) - 30,
                           $urandom_range(0, 200) - 100,
                           d * (23170 + $urandom_range(0, 60) - 30),
                           $urandom_range(0, 200) - 100), 1'b0);
      end else begin
        queue_quat(quat_t'({$urandom(), $urandom()}), 1'b0);
      end
    end
  endtask

  // Predict each accepted word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_angles.push_back(euler_of(in_i));
      sent_cnt++;
      took = 1'b1;
    end
  end

  // Drive input words at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || took) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (pending_quats.size() > 0) begin
          if (drain_marks[0] && expected_angles.size() > 0) begin
            // Hold off until the pipe has drained
            in_valid_i <= 1'b0;
          end else begin
            if (drain_marks[0]) drain_cnt++;
            in_i <= pending_quats.pop_front();
            void'(drain_marks.pop_front());
            in_valid_i <= 1'b1;
            if (pending_quats.size() % 200 == 0) burst_mode = ~burst_mode;
            send_gap = pick_gap();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      took = 1'b0;
      // Random receiver stalls
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 9) < 3) stall_left = pick_gap();
      end
    end
  end

  // Check results against the oldest prediction
  always @(posedge clk_i) begin
    euler_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_angles.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result word %p", out_o);
      end else begin
        want = expected_angles.pop_front();
        checked_cnt++;
        if (want.pitch_clamped) clamped_cnt++;
        if (out_o.roll !== want.roll || out_o.pitch !== want.pitch ||
            out_o.yaw !== want.yaw || out_o.pitch_clamped !== want.pitch_clamped) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch at result %0d: exp roll %0d pitch %0d yaw %0d clamp %0b",
                     checked_cnt, want.roll, want.pitch, want.yaw, want.pitch_clamped);
            $display("                        got roll %0d pitch %0d yaw %0d clamp %0b",
                     out_o.roll, out_o.pitch, out_o.yaw, out_o.pitch_clamped);
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    fill_stimulus();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_quats.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_angles.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_angles.size() > 0) mismatch_cnt++;
    $display("sent %0d words, checked %0d results (%0d with pitch clamped)",
             sent_cnt, checked_cnt, clamped_cnt);
    $display("pipe drained %0d times mid-run, %0d mismatches", drain_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[quaternion_to_euler.f]
sv/q2e_pkg.sv
sv/q2e_sqrt_cell.sv
sv/q2e_cordic_cell.sv
sv/quaternion_to_euler.sv
tb/quaternion_to_euler_tb.sv
